// ----- design/ati_pkg.sv -----
// ----------------------------------------------------------------------------
// ati_pkg
// Shared types and constants of the ADC table interpolation block.
// ----------------------------------------------------------------------------
`default_nettype none

package ati_pkg;

   // field widths
   localparam int KEY_W   = 17;
   localparam int VAL_W   = 16;
   localparam int RES_W   = 17;
   localparam int DV_W    = VAL_W + 1;        // value difference
   localparam int DS_W    = KEY_W + 1;        // key difference
   localparam int NUM_W   = DV_W + DS_W;      // interpolation product
   localparam int MAG_W   = NUM_W - 1;        // product magnitude
   localparam int DVS_W   = DS_W - 1;         // divisor magnitude
   localparam int ENTRY_W = KEY_W + VAL_W;    // one stored table entry

   localparam int DEFAULT_BANKS   = 16;
   localparam int DEFAULT_ENTRIES = 64;

   localparam logic signed [RES_W-1:0] FAKE_VALUE = 17'sd300;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_BANK    = 2'd1,
      OP_CONVERT = 2'd2
   } op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ----- design/ati_req_if.sv -----
// ----------------------------------------------------------------------------
// ati_req_if
// Request channel: valid/ready handshake carrying one table or convert item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ati_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [3:0]         bank;
   logic [5:0]         entry_index;
   logic signed [16:0] entry_key;
   logic signed [15:0] entry_value;
   logic [6:0]         entry_count;
   logic               descending;
   logic signed [16:0] sample;
   logic               fake;

   modport source (output valid, operation, bank, entry_index, entry_key, entry_value,
                   entry_count, descending, sample, fake, input ready);
   modport sink   (input valid, operation, bank, entry_index, entry_key, entry_value,
                   entry_count, descending, sample, fake, output ready);
endinterface

`default_nettype wire

// ----- design/ati_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ati_rsp_if
// Response channel: valid/ready handshake carrying one conversion result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ati_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] result_value;
   logic               valid_res;
   logic               bank_error;

   modport source (output valid, result_value, valid_res, bank_error, input ready);
   modport sink   (input valid, result_value, valid_res, bank_error, output ready);
endinterface

`default_nettype wire

// ----- design/ati_ram.sv -----
// ----------------------------------------------------------------------------
// ati_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ati_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/ati_div.sv -----
// ----------------------------------------------------------------------------
// ati_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ati_div import ati_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [MAG_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output div_status_type        status,
   output logic      [MAG_W-1:0] quotient
);

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0]   rem_shift;
   logic [DVS_W:0]   rem_sub;
   logic             ge;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[MAG_W-1]};
      rem_sub   = rem_shift - {1'b0, dvs_ff};
      ge        = rem_shift >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MAG_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         rem_in = ge ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign status   = '{busy: busy_ff, done: done_ff};
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- design/adc_table_interpolate.sv -----
// ----------------------------------------------------------------------------
// adc_table_interpolate
// Piecewise-linear conversion of an ADC sample through banked key/value tables.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries write items (load one key/value entry), bank items (set a
//   bank's entry count and key order) and convert items. Only convert items
//   produce an item on rsp_bus; write and bank items finish in the cycle they
//   are accepted.
//   A convert item that is fake, hits an empty bank or carries an invalid
//   sample is answered in the accept cycle (result visible next cycle).
//   A full conversion spends the accept cycle, reads the first and last
//   entries, runs a binary search (a read state and a compare state per
//   probe) and closes it, reads the two bracketing entries, multiplies,
//   starts the divider and divides serially at one quotient bit per cycle,
//   with the result visible in the cycle after. The single table RAM port
//   and the serial divider set the length of a conversion.
//   The block works on one item at a time; req ready drops while a
//   conversion runs. The result sits in an output register: ready returns
//   when that register is empty or is being taken in the same cycle, so a
//   stalled receiver holds the block off only once it owns a result.
//   Reset empties every bank (count 0, ascending); table contents stay
//   undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_table_interpolate import ati_pkg::*; #(
   parameter int BANKS            = DEFAULT_BANKS,
   parameter int ENTRIES_PER_BANK = DEFAULT_ENTRIES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ati_req_if.sink    req_bus,
   ati_rsp_if.source  rsp_bus
);

   localparam int DEPTH = BANKS * ENTRIES_PER_BANK;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(ENTRIES_PER_BANK);
   localparam int CW    = $clog2(ENTRIES_PER_BANK + 1);
   localparam int BW    = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int SW    = IW + 2;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_FIRST = 10'b00_0000_0010,
      S_LAST  = 10'b00_0000_0100,
      S_PROBE = 10'b00_0000_1000,
      S_CMP   = 10'b00_0001_0000,
      S_LO    = 10'b00_0010_0000,
      S_HI    = 10'b00_0100_0000,
      S_MUL   = 10'b00_1000_0000,
      S_START = 10'b01_0000_0000,
      S_DIV   = 10'b10_0000_0000
   } state_type;

   // control
   state_type                 state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]             bank_count_ff [BANKS];
   logic                      bank_order_ff [BANKS];

   // working registers
   logic [AW-1:0]             base_ff, base_in;
   logic [CW-1:0]             n_ff, n_in;
   logic                      desc_ff, desc_in;
   logic signed [KEY_W-1:0]   sample_ff, sample_in;
   logic signed [KEY_W-1:0]   k0_ff, k0_in;
   logic signed [VAL_W-1:0]   v0_ff, v0_in;
   logic signed [SW-1:0]      lo_ff, lo_in;
   logic signed [SW-1:0]      hi_ff, hi_in;
   logic [IW-1:0]             mid_ff, mid_in;
   logic signed [KEY_W-1:0]   klo_ff, klo_in;
   logic signed [VAL_W-1:0]   vlo_ff, vlo_in;
   logic signed [VAL_W-1:0]   vhi_ff, vhi_in;
   logic signed [DV_W-1:0]    dv_ff, dv_in;
   logic signed [DS_W-1:0]    ds_ff, ds_in;
   logic signed [DS_W-1:0]    den_ff, den_in;
   logic signed [NUM_W-1:0]   num_ff, num_in;
   logic                      sign_ff, sign_in;
   logic signed [RES_W-1:0]   res_value_ff, res_value_in;
   logic                      res_ok_ff, res_ok_in;
   logic                      res_berr_ff, res_berr_in;

   // request decode
   op_type                    req_op;
   logic                      accept;
   logic                      bank_ok;
   logic                      idx_ok;
   logic [BW-1:0]             bidx;
   logic [CW-1:0]             cur_n;
   logic [CW-1:0]             sat_count;
   logic [AW-1:0]             req_base;
   logic [AW-1:0]             wr_addr;
   logic                      wr_en;
   logic                      bank_we;
   logic                      req_invalid;

   // search and arithmetic
   logic signed [SW-1:0]      nm1_s;
   logic [SW-1:0]             mid_sum;
   logic signed [SW-1:0]      lo_c;
   logic signed [SW-1:0]      hi_c;
   logic [AW-1:0]             rd_addr;
   logic [ENTRY_W-1:0]        rd_data;
   logic signed [KEY_W-1:0]   rd_key;
   logic signed [VAL_W-1:0]   rd_val;
   logic                      go_down;
   logic                      go_up;
   logic                      div_start;
   logic [MAG_W-1:0]          div_dividend;
   logic [DVS_W-1:0]          div_divisor;
   logic [MAG_W-1:0]          div_quotient;
   div_status_type            div_status;
   logic signed [NUM_W-1:0]   num_abs;
   logic signed [DS_W-1:0]    den_abs;
   logic signed [MAG_W:0]     q_signed;
   logic signed [NUM_W:0]     interp;
   logic                      finish;
   logic signed [RES_W-1:0]   fin_value;
   logic                      fin_ok;
   logic                      fin_berr;

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   assign req_op      = op_type'(req_bus.operation);
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept      = req_bus.valid && req_bus.ready;
   assign bank_ok     = 32'(req_bus.bank) < BANKS;
   assign idx_ok      = 32'(req_bus.entry_index) < ENTRIES_PER_BANK;
   assign bidx        = BW'(32'(req_bus.bank));
   assign cur_n       = bank_ok ? bank_count_ff[bidx] : '0;
   assign sat_count   = (32'(req_bus.entry_count) > ENTRIES_PER_BANK) ?
                        CW'(ENTRIES_PER_BANK) : CW'(32'(req_bus.entry_count));
   assign req_base    = AW'(32'(req_bus.bank) * ENTRIES_PER_BANK);
   assign wr_addr     = AW'(32'(req_bus.bank) * ENTRIES_PER_BANK +
                            32'(req_bus.entry_index));
   assign wr_en       = accept && (req_op == OP_WRITE) && bank_ok && idx_ok;
   assign bank_we     = accept && (req_op == OP_BANK) && bank_ok;
   // ascending: negative sample is invalid; descending: zero too
   assign req_invalid = bank_order_ff[bidx] ? (req_bus.sample <= 0) : (req_bus.sample < 0);

   // ---------------------------------------------------------------------
   // Table RAM: key in the upper bits, value in the lower
   // ---------------------------------------------------------------------
   ati_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_bus.entry_key, req_bus.entry_value}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key = $signed(rd_data[ENTRY_W-1:VAL_W]);
   assign rd_val = $signed(rd_data[VAL_W-1:0]);

   // ---------------------------------------------------------------------
   // Serial divider
   // ---------------------------------------------------------------------
   assign num_abs      = num_ff[NUM_W-1] ? -num_ff : num_ff;
   assign den_abs      = den_ff[DS_W-1] ? -den_ff : den_ff;
   assign div_dividend = num_abs[MAG_W-1:0];
   assign div_divisor  = den_abs[DVS_W-1:0];

   ati_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------------
   // Search helpers
   // ---------------------------------------------------------------------
   assign nm1_s   = $signed(SW'(n_ff)) - $signed(SW'(1));
   assign mid_sum = SW'(lo_ff + hi_ff);
   assign lo_c    = (lo_ff > nm1_s) ? nm1_s : lo_ff;
   assign hi_c    = (hi_ff < 0) ? '0 : hi_ff;

   assign go_down = desc_ff ? (rd_key < sample_ff) : (rd_key > sample_ff);
   assign go_up   = desc_ff ? (rd_key > sample_ff) : (rd_key < sample_ff);

   assign q_signed = sign_ff ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});
   assign interp   = (NUM_W + 1)'(q_signed) + (NUM_W + 1)'(vhi_ff);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      desc_in      = desc_ff;
      sample_in    = sample_ff;
      k0_in        = k0_ff;
      v0_in        = v0_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      klo_in       = klo_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      dv_in        = dv_ff;
      ds_in        = ds_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      sign_in      = sign_ff;
      rd_addr      = '0;
      div_start    = 1'b0;
      finish       = 1'b0;
      fin_value    = '0;
      fin_ok       = 1'b0;
      fin_berr     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_CONVERT)) begin
               priority if (req_bus.fake) begin
                  finish    = 1'b1;
                  fin_value = FAKE_VALUE;
                  fin_ok    = 1'b1;
               end else if (!bank_ok || (cur_n == '0)) begin
                  finish   = 1'b1;
                  fin_berr = 1'b1;
               end else if (req_invalid) begin
                  // descending tables echo the sample
                  finish    = 1'b1;
                  fin_value = bank_order_ff[bidx] ? req_bus.sample : '0;
               end else begin
                  base_in   = req_base;
                  n_in      = cur_n;
                  desc_in   = bank_order_ff[bidx];
                  sample_in = req_bus.sample;
                  rd_addr   = req_base;
                  state_in  = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            k0_in    = rd_key;
            v0_in    = rd_val;
            rd_addr  = base_ff + AW'(nm1_s[IW-1:0]);
            state_in = S_LAST;
         end
         S_LAST: begin
            priority if (desc_ff ? (k0_ff <= sample_ff) : (k0_ff >= sample_ff)) begin
               finish    = 1'b1;
               fin_value = RES_W'(v0_ff);
               fin_ok    = 1'b1;
               state_in  = S_IDLE;
            end else if (desc_ff ? (rd_key >= sample_ff) : (rd_key <= sample_ff)) begin
               finish    = 1'b1;
               fin_value = RES_W'(rd_val);
               fin_ok    = 1'b1;
               state_in  = S_IDLE;
            end else begin
               lo_in    = '0;
               hi_in    = nm1_s;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff <= hi_ff) begin
               mid_in   = mid_sum[IW:1];
               rd_addr  = base_ff + AW'(mid_sum[IW:1]);
               state_in = S_CMP;
            end else begin
               // search ended: fetch the bracketing pair
               lo_in    = lo_c;
               hi_in    = hi_c;
               rd_addr  = base_ff + AW'(lo_c[IW-1:0]);
               state_in = S_LO;
            end
         end
         S_CMP: begin
            priority if (go_down) begin
               hi_in    = $signed({2'b00, mid_ff}) - $signed(SW'(1));
               state_in = S_PROBE;
            end else if (go_up) begin
               lo_in    = $signed({2'b00, mid_ff}) + $signed(SW'(1));
               state_in = S_PROBE;
            end else begin
               finish    = 1'b1;
               fin_value = RES_W'(rd_val);
               fin_ok    = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_LO: begin
            klo_in   = rd_key;
            vlo_in   = rd_val;
            rd_addr  = base_ff + AW'(hi_ff[IW-1:0]);
            state_in = S_HI;
         end
         S_HI: begin
            vhi_in   = rd_val;
            dv_in    = DV_W'(vlo_ff) - DV_W'(rd_val);
            ds_in    = DS_W'(sample_ff) - DS_W'(rd_key);
            den_in   = DS_W'(klo_ff) - DS_W'(rd_key);
            state_in = S_MUL;
         end
         S_MUL: begin
            num_in   = NUM_W'(dv_ff) * NUM_W'(ds_ff);
            state_in = S_START;
         end
         S_START: begin
            if (den_ff == '0) begin
               finish    = 1'b1;
               fin_value = (desc_ff && vhi_ff < 0) ? '0 : RES_W'(vhi_ff);
               fin_ok    = 1'b1;
               state_in  = S_IDLE;
            end else begin
               div_start = 1'b1;
               sign_in   = num_ff[NUM_W-1] ^ den_ff[DS_W-1];
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               // descending tables clamp a negative result at zero
               finish    = 1'b1;
               fin_value = (desc_ff && interp < 0) ? '0 : interp[RES_W-1:0];
               fin_ok    = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: drop when taken, load on finish
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      res_value_in = res_value_ff;
      res_ok_in    = res_ok_ff;
      res_berr_in  = res_berr_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         res_value_in = fin_value;
         res_ok_in    = fin_ok;
         res_berr_in  = fin_berr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         bank_count_ff <= '{default: '0};
         bank_order_ff <= '{default: 1'b0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (bank_we) begin
            bank_count_ff[bidx] <= sat_count;
            bank_order_ff[bidx] <= req_bus.descending;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      n_ff         <= n_in;
      desc_ff      <= desc_in;
      sample_ff    <= sample_in;
      k0_ff        <= k0_in;
      v0_ff        <= v0_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      klo_ff       <= klo_in;
      vlo_ff       <= vlo_in;
      vhi_ff       <= vhi_in;
      dv_ff        <= dv_in;
      ds_ff        <= ds_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      sign_ff      <= sign_in;
      res_value_ff <= res_value_in;
      res_ok_ff    <= res_ok_in;
      res_berr_ff  <= res_berr_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = res_value_ff;
   assign rsp_bus.valid_res    = res_ok_ff;
   assign rsp_bus.bank_error   = res_berr_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_only_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result pending while a conversion runs");

   a_probe_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> ((lo_ff >= 0) && (hi_ff <= nm1_s)))
      else $error("search bounds left the bank");

   a_div_start_free : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_div_done_result : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV) && div_status.done) |=> rsp_valid_ff)
      else $error("divide finished without a result");

endmodule

`default_nettype wire

// ----- tb/tb_adc_table_interpolate.sv -----
// ----------------------------------------------------------------------------
// tb_adc_table_interpolate
// Self-checking bench for the ADC table interpolation block: loads banks with
// sorted key/value tables, converts directed and random samples, and checks
// every result against a local predictor of the search and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adc_table_interpolate import ati_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBANK      = 16;
   localparam int NENT       = 64;
   localparam int STALL_MAX  = 20000;
   localparam int TAIL_CYC   = 80;
   localparam int PHASE_ITEMS = 200;

   // one request item as driven onto the bus
   typedef struct {
      op_type             op;
      logic [3:0]         bank;
      logic [5:0]         idx;
      logic signed [16:0] key;
      logic signed [15:0] val;
      logic [6:0]         cnt;
      logic               desc;
      logic signed [16:0] sample;
      logic               fake;
   } table_item_type;

   typedef struct {
      logic signed [16:0] value;
      logic               ok;
      logic               bank_err;
   } conv_result_type;

   // ------------------------------------------------------------------------
   // Scoreboard: own copy of the tables, predicts one result per convert.
   // ------------------------------------------------------------------------
   class conv_scoreboard;
      int                 key_tab [NBANK*NENT];
      int                 val_tab [NBANK*NENT];
      int                 cnt_tab [NBANK];
      bit                 desc_tab [NBANK];
      conv_result_type    pending [$];
      int                 errors;
      int                 checked;

      function new();
         foreach (cnt_tab[i]) begin
            cnt_tab[i]  = 0;
            desc_tab[i] = 0;
         end
         errors  = 0;
         checked = 0;
      endfunction

      // piecewise-linear lookup with binary search
      function longint interpolate(int base, int n, bit desc, longint s);
         longint lo, hi, mid, k, num, den, r;
         lo = 0;
         hi = n - 1;
         if (desc ? (key_tab[base] <= s) : (key_tab[base] >= s))
            return val_tab[base];
         if (desc ? (key_tab[base+n-1] >= s) : (key_tab[base+n-1] <= s))
            return val_tab[base+n-1];
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            k = key_tab[base+mid];
            if (desc ? (k < s) : (k > s)) hi = mid - 1;
            else if (desc ? (k > s) : (k < s)) lo = mid + 1;
            else return val_tab[base+mid];
         end
         if (hi < 0) hi = 0;
         if (lo > n - 1) lo = n - 1;
         num = (longint'(val_tab[base+lo]) - val_tab[base+hi]) * (s - key_tab[base+hi]);
         den = longint'(key_tab[base+lo]) - key_tab[base+hi];
         r = val_tab[base+hi];
         if (den != 0) r += num / den;   // SV division truncates toward zero
         if (desc && r < 0) r = 0;
         return r;
      endfunction

      function void note_item(table_item_type it);
         conv_result_type res;
         int              b;
         longint          s;
         b = it.bank;
         case (it.op)
            OP_WRITE: begin
               key_tab[b*NENT + it.idx] = it.key;
               val_tab[b*NENT + it.idx] = it.val;
            end
            OP_BANK: begin
               cnt_tab[b]  = (it.cnt > NENT) ? NENT : it.cnt;
               desc_tab[b] = it.desc;
            end
            OP_CONVERT: begin
               res = '{value: '0, ok: 1'b0, bank_err: 1'b0};
               s = it.sample;
               if (it.fake) begin
                  res.value = FAKE_VALUE;
                  res.ok    = 1'b1;
               end else if (cnt_tab[b] == 0) begin
                  res.bank_err = 1'b1;
               end else if (desc_tab[b] ? (s <= 0) : (s < 0)) begin
                  res.value = desc_tab[b] ? it.sample : '0;
               end else begin
                  res.value = 17'(interpolate(b*NENT, cnt_tab[b], desc_tab[b], s));
                  res.ok    = 1'b1;
               end
               pending.push_back(res);
            end
            default: ;
         endcase
      endfunction

      task check_result(conv_result_type got);
         conv_result_type exp_r;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d", got.value));
            return;
         end
         exp_r = pending.pop_front();
         if (got.value !== exp_r.value)
            report_mismatch($sformatf("result_value got %0d want %0d",
                                      got.value, exp_r.value));
         if (got.ok !== exp_r.ok)
            report_mismatch($sformatf("valid_res got %b want %b", got.ok, exp_r.ok));
         if (got.bank_err !== exp_r.bank_err)
            report_mismatch($sformatf("bank_error got %b want %b",
                                      got.bank_err, exp_r.bank_err));
      endtask

      task report_mismatch(string msg);
         errors++;
         $display("%0t mismatch: %s", $realtime, msg);
      endtask
   endclass

   logic clock;
   logic reset;

   ati_req_if req_bus ();
   ati_rsp_if rsp_bus ();

   adc_table_interpolate i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   conv_scoreboard sb;
   int  send_idle_pct;   // chance the sender holds off before an item
   int  recv_idle_pct;   // chance the receiver drops ready in a cycle
   int  idle_cycles;     // cycles without any handshake
   int  n_items;
   int  n_convert;
   int  n_interp;
   // per bank: entries written so far, so converts never read unwritten slots
   int  written_upto [NBANK];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Receiver: random ready at the falling edge, check at the rising edge.
   // ------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result('{rsp_bus.result_value, rsp_bus.valid_res, rsp_bus.bank_error});
   end

   // watchdog: count cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_MAX) begin
         $display("watchdog: no progress for %0d cycles", STALL_MAX);
         $display("[adc_table_interpolate] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sender: valid stays up after an item until the next call idles or
   // replaces it; drain() drops it.
   // ------------------------------------------------------------------------
   task automatic send_item(table_item_type it);
      // hold off at random before the item
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid       <= 1;
      req_bus.operation   <= it.op;
      req_bus.bank        <= it.bank;
      req_bus.entry_index <= it.idx;
      req_bus.entry_key   <= it.key;
      req_bus.entry_value <= it.val;
      req_bus.entry_count <= it.cnt;
      req_bus.descending  <= it.desc;
      req_bus.sample      <= it.sample;
      req_bus.fake        <= it.fake;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_item(it);
      n_items++;
      if (it.op == OP_CONVERT) n_convert++;
      @(negedge clock);
   endtask

   function automatic table_item_type blank_item();
      table_item_type it;
      it.op = OP_CONVERT; it.bank = '0; it.idx = '0; it.key = '0; it.val = '0;
      it.cnt = '0; it.desc = 1'b0; it.sample = '0; it.fake = 1'b0;
      return it;
   endfunction

   task automatic write_entry(int b, int i, int k, int v);
      table_item_type it;
      it = blank_item();
      it.op = OP_WRITE; it.bank = 4'(b); it.idx = 6'(i); it.key = 17'(k); it.val = 16'(v);
      it.cnt = 7'($urandom); it.sample = 17'($urandom);
      it.desc = 1'($urandom); it.fake = 1'($urandom);
      send_item(it);
      if (i >= written_upto[b]) written_upto[b] = i + 1;
   endtask

   task automatic set_bank(int b, int n, bit d);
      table_item_type it;
      it = blank_item();
      it.op = OP_BANK; it.bank = 4'(b); it.cnt = 7'(n); it.desc = d;
      it.idx = 6'($urandom); it.key = 17'($urandom); it.val = 16'($urandom);
      it.sample = 17'($urandom);
      send_item(it);
   endtask

   task automatic convert(int b, int s, bit fk);
      table_item_type it;
      it = blank_item();
      it.op = OP_CONVERT; it.bank = 4'(b); it.sample = 17'(s); it.fake = fk;
      it.idx = 6'($urandom); it.key = 17'($urandom); it.val = 16'($urandom);
      it.cnt = 7'($urandom); it.desc = 1'($urandom);
      send_item(it);
   endtask

   // load a full sorted table into bank b, n entries, given order
   task automatic load_table(int b, int n, bit d, int kmin, int kmax);
      int step, k, i;
      step = (kmax - kmin) / ((n > 1) ? n - 1 : 1);
      if (step < 1) step = 1;
      for (i = 0; i < n; i++) begin
         k = d ? kmax - i*step : kmin + i*step;
         write_entry(b, i, k, $signed(16'($urandom)));
      end
      set_bank(b, n, d);
   endtask

   // sample that lands among the bank's keys, a bit past either end, or at random
   function automatic int pick_sample(int b);
      int lo, hi, n, r;
      n = sb.cnt_tab[b];
      if (n == 0) return $signed(17'($urandom));
      lo = sb.key_tab[b*NENT];
      hi = sb.key_tab[b*NENT + n - 1];
      if (lo > hi) begin r = lo; lo = hi; hi = r; end
      case ($urandom_range(9))
         0: return $signed(17'($urandom));
         1: return sb.key_tab[b*NENT + $urandom_range(n-1)];
         default: begin
            r = lo - 50 + int'($urandom_range(hi - lo + 100));
            if (r > 65535) r = 65535;
            if (r < -65536) r = -65536;
            return r;
         end
      endcase
   endfunction

   task automatic random_item();
      int b, r;
      b = $urandom_range(NBANK-1);
      r = $urandom_range(99);
      if (r < 70) begin
         // convert; never touch a configured count beyond what was written
         if (sb.cnt_tab[b] > written_upto[b]) b = 0;
         convert(b, pick_sample(b), ($urandom_range(19) == 0));
         if (!sb.pending[$].bank_err && sb.pending[$].ok && !(b == 0 && 0)) n_interp++;
      end else if (r < 85) begin
         // overwrite an already-written entry (entry 0 if none is), keeping the table mostly sane
         if (written_upto[b] > 0)
            write_entry(b, $urandom_range(written_upto[b]-1),
                        $signed(17'($urandom)), $signed(16'($urandom)));
         else
            write_entry(b, 0, $signed(17'($urandom)), $signed(16'($urandom)));
      end else if (r < 95) begin
         // resize within the written range; sometimes ask for too many
         if (written_upto[b] == NENT && $urandom_range(3) == 0)
            set_bank(b, $urandom_range(127, NENT), 1'($urandom));
         else
            set_bank(b, $urandom_range(written_upto[b]), 1'($urandom));
      end else begin
         load_table(b, $urandom_range(1, 12), 1'($urandom),
                    -1000 - int'($urandom_range(60000)),
                    1000 + int'($urandom_range(60000)));
      end
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYC) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int ph, i;
      table_item_type odd_it;
      sb = new();
      n_items = 0; n_convert = 0; n_interp = 0; idle_cycles = 0;
      foreach (written_upto[j]) written_upto[j] = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_bus.valid = 0;
      req_bus.operation = OP_WRITE;
      req_bus.bank = 0; req_bus.entry_index = 0; req_bus.entry_key = 0;
      req_bus.entry_value = 0; req_bus.entry_count = 0; req_bus.descending = 0;
      req_bus.sample = 0; req_bus.fake = 0;
      reset = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // ---- directed: empty bank, fake, extremes, both orders ----
      convert(3, 100, 0);                      // empty bank
      convert(15, -65536, 1);                  // fake wins over empty
      write_entry(0, 0, -100, -32768);
      write_entry(0, 1, 0, 0);
      write_entry(0, 2, 65535, 32767);
      set_bank(0, 3, 0);
      convert(0, -1, 0);                       // ascending invalid sample
      convert(0, 0, 0);                        // exact key
      convert(0, 65535, 0);                    // clamp to last
      convert(0, 40000, 0);                    // interpolate
      write_entry(1, 0, 65535, -32768);
      write_entry(1, 1, 1, 32767);
      write_entry(1, 2, -65536, -32768);
      set_bank(1, 3, 1);
      convert(1, 0, 0);                        // descending invalid: echoed
      convert(1, -65536, 0);
      convert(1, 65535, 0);                    // clamp to first
      convert(1, 30000, 0);                    // interpolated, maybe negative
      set_bank(1, 1, 1);
      convert(1, 5, 0);                        // single entry bank
      set_bank(2, 127, 0);                     // count saturates, then disable
      set_bank(2, 0, 0);
      convert(2, 5, 0);
      // unsupported operation code must be ignored
      odd_it = blank_item();
      odd_it.op = op_type'(2'd3);
      odd_it.bank = 4'd0;
      odd_it.sample = 17'sd5;
      send_item(odd_it);
      // full 64-entry tables on banks 4 and 5, a two-entry table on bank 6
      load_table(4, NENT, 0, -65536, 65535);
      load_table(5, NENT, 1, -60000, 60000);
      load_table(6, 2, 0, 10, 20);
      drain();

      // ---- random phases with different idling ----
      for (ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 45 : 0;
         recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 18 : 0;
         for (i = 0; i < PHASE_ITEMS; i++) random_item();
         drain();
      end

      $display("covered %0d items, %0d conversions over %0d banks, both key orders",
               n_items, n_convert, NBANK);
      $display("results checked: %0d, mismatches: %0d", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[adc_table_interpolate] OK");
      else
         $display("[adc_table_interpolate] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ----- adc_table_interpolate.f -----
design/ati_pkg.sv
design/ati_req_if.sv
design/ati_rsp_if.sv
design/ati_ram.sv
design/ati_div.sv
design/adc_table_interpolate.sv
tb/tb_adc_table_interpolate.sv
